@@ sv/mrtb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrtb_pkg
// Types and constants shared by the read threshold bin detector files.
// ----------------------------------------------------------------------------
package mrtb_pkg;

  localparam int MaxReads   = 7;
  localparam int SampleBits = 12;
  localparam int CountBits  = 16;
  localparam int CntW       = $clog2(MaxReads + 1);
  localparam int BinW       = 3;

  typedef enum logic {
    FuncLoad     = 1'b0,
    FuncClassify = 1'b1
  } func_e;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [CntW-1:0]              cnt_t;
  typedef logic [BinW-1:0]              bin_t;
  typedef logic [CountBits-1:0]         errcnt_t;

  typedef struct packed {
    func_e   func;
    sample_t threshold;
    logic    start_table;
    sample_t sample;
    logic    sent_bit;
    logic    last_sample;
  } in_t;

  typedef struct packed {
    bin_t                bin_id;
    logic [MaxReads-1:0] soft_code;
    logic                hard_error;
    errcnt_t             error_count;
    logic                block_end;
  } out_t;

endpackage

@@ sv/mrtb_in_if.sv @@
// ----------------------------------------------------------------------------
// mrtb_in_if
// Request channel into the detector: valid/ready with load or classify payload.
// ----------------------------------------------------------------------------
interface mrtb_in_if;
  import mrtb_pkg::*;

  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/mrtb_out_if.sv @@
// ----------------------------------------------------------------------------
// mrtb_out_if
// Result channel out of the detector: valid/ready with bin and error payload.
// ----------------------------------------------------------------------------
interface mrtb_out_if;
  import mrtb_pkg::*;

  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/multi_read_threshold_bin_detector_core.sv @@
// ----------------------------------------------------------------------------
// multi_read_threshold_bin_detector_core
// Sorted read threshold table with bin map; classifies samples into bins,
// builds the soft-read code and counts hard-decision errors per block.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | results
//  ---------+-----+------------------------------------------------+--------
//  in_i     | in  | func, threshold, start_table, sample, sent_bit, | -
//           |     | last_sample                                    |
//  out_o    | out | bin_id, soft_code, hard_error, error_count,    | 1 per
//           |     | block_end                                      | classify
//
//  One request per cycle while no result is stalled. Requests pass the input register,
//  then the table update or compare/priority pick into the result register.
//  Load requests give no result and never wait on the result side.
//  A stalled result holds a classify request in the input register; loads
//  behind it wait there too, so table updates stay in order.
//  Reset clears the table, bin map and error count at once.
// ----------------------------------------------------------------------------
module multi_read_threshold_bin_detector_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrtb_in_if.sink    in_i,
  mrtb_out_if.source out_o
);
  import mrtb_pkg::*;

  logic    s1_valid_q;
  in_t     s1_q;
  logic    out_valid_q;
  out_t    out_q;

  sample_t sorted_q [MaxReads];
  sample_t orig_q   [MaxReads];
  bin_t    bin_q    [MaxReads+1];
  cnt_t    ref_cnt_q;
  errcnt_t err_cnt_q;

  logic    s1_is_load, out_free, s1_adv, in_acc;

  assign s1_is_load = (s1_q.func == FuncLoad);
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (s1_is_load || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // --------------------------------------------------------------------------
  // Threshold insertion
  // --------------------------------------------------------------------------
  sample_t sb [MaxReads];
  sample_t sprev [MaxReads];
  sample_t ob [MaxReads];
  bin_t    bb [MaxReads+1];
  bin_t    bprev [MaxReads+1];
  logic    ge [MaxReads+1];
  logic    geprev [MaxReads+1];
  cnt_t    kb;
  logic    ins_ok;
  sample_t sorted_d [MaxReads];
  sample_t orig_d   [MaxReads];
  bin_t    bin_d    [MaxReads+1];
  cnt_t    ref_cnt_d;

  always_comb begin
    for (int j = 0; j < MaxReads; j++) begin
      sb[j] = s1_q.start_table ? '0 : sorted_q[j];
      ob[j] = s1_q.start_table ? '0 : orig_q[j];
    end
    for (int j = 0; j <= MaxReads; j++) begin
      bb[j] = s1_q.start_table ? '0 : bin_q[j];
    end
    kb     = s1_q.start_table ? '0 : ref_cnt_q;
    ins_ok = (kb < cnt_t'(MaxReads));

    // ge: entry lies at or after the insertion point (list is ascending)
    for (int j = 0; j <= MaxReads; j++) begin
      if ((j < MaxReads) && (j < int'(kb))) begin
        ge[j] = (s1_q.threshold < sb[j]);
      end else begin
        ge[j] = 1'b1;
      end
    end
    geprev[0] = 1'b0;
    sprev[0]  = sb[0];
    bprev[0]  = bb[0];
    for (int j = 1; j <= MaxReads; j++) begin
      geprev[j] = ge[j-1];
      bprev[j]  = bb[j-1];
      if (j < MaxReads) begin
        sprev[j] = sb[j-1];
      end
    end

    for (int j = 0; j < MaxReads; j++) begin
      sorted_d[j] = sb[j];
      if (j <= int'(kb)) begin
        if (ge[j] && !geprev[j]) begin
          sorted_d[j] = s1_q.threshold;
        end else if (ge[j]) begin
          sorted_d[j] = sprev[j];
        end
      end
      orig_d[j] = (j == int'(kb)) ? s1_q.threshold : ob[j];
    end
    for (int j = 0; j <= MaxReads; j++) begin
      bin_d[j] = bb[j];
      if (j <= int'(kb) + 1) begin
        if (ge[j] && !geprev[j]) begin
          bin_d[j] = bin_t'(kb + cnt_t'(1));
        end else if (ge[j]) begin
          bin_d[j] = bprev[j];
        end
      end
    end
    ref_cnt_d = kb + cnt_t'(1);
  end

  // --------------------------------------------------------------------------
  // Classification
  // --------------------------------------------------------------------------
  logic                below [MaxReads];
  logic                first [MaxReads];
  logic                any_below;
  sample_t             bound;
  logic [MaxReads-1:0] raw_rev;
  logic [MaxReads-1:0] code;
  bin_t                bin_sel;
  logic                hard_err;
  errcnt_t             cnt_next;

  always_comb begin
    any_below = 1'b0;
    bound     = '0;
    for (int j = 0; j < MaxReads; j++) begin
      below[j] = (j < int'(ref_cnt_q)) && (s1_q.sample < sorted_q[j]);
    end
    for (int j = 0; j < MaxReads; j++) begin
      first[j]  = below[j] && ((j == 0) || !below[(j == 0) ? 0 : j-1]);
      any_below = any_below | below[j];
      bound     = bound | (first[j] ? sorted_q[j] : '0);
    end
    // read 0 lands in bit ref_count-1
    for (int j = 0; j < MaxReads; j++) begin
      raw_rev[MaxReads-1-j] = (j < int'(ref_cnt_q)) && (bound <= orig_q[j]);
    end
    code = any_below ? (raw_rev >> (cnt_t'(MaxReads) - ref_cnt_q)) : '0;

    bin_sel = '0;
    for (int j = 0; j <= MaxReads; j++) begin
      if (((j < MaxReads) && first[(j < MaxReads) ? j : 0]) ||
          (!any_below && (j == int'(ref_cnt_q)))) begin
        bin_sel = bin_sel | bin_q[j];
      end
    end

    hard_err = s1_q.sample[SampleBits-1] ^ s1_q.sent_bit;
    cnt_next = (hard_err && (err_cnt_q != '1)) ? err_cnt_q + errcnt_t'(1) : err_cnt_q;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ref_cnt_q   <= '0;
      err_cnt_q   <= '0;
      for (int j = 0; j < MaxReads; j++) begin
        sorted_q[j] <= '0;
        orig_q[j]   <= '0;
      end
      for (int j = 0; j <= MaxReads; j++) begin
        bin_q[j] <= '0;
      end
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_adv && !s1_is_load;
      end
      if (s1_adv && s1_is_load && ins_ok) begin
        sorted_q  <= sorted_d;
        orig_q    <= orig_d;
        bin_q     <= bin_d;
        ref_cnt_q <= ref_cnt_d;
      end
      if (s1_adv && !s1_is_load) begin
        err_cnt_q <= s1_q.last_sample ? '0 : cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_i.payload;
    end
    if (s1_adv && !s1_is_load) begin
      out_q.bin_id      <= bin_sel;
      out_q.soft_code   <= code;
      out_q.hard_error  <= hard_err;
      out_q.error_count <= cnt_next;
      out_q.block_end   <= s1_q.last_sample;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic sorted_ok;

  always_comb begin
    sorted_ok = 1'b1;
    for (int j = 0; j < MaxReads - 1; j++) begin
      if ((j + 1 < int'(ref_cnt_q)) && (sorted_q[j] > sorted_q[j+1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni) sorted_ok)
    else $error("threshold list out of order");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_cnt_q <= cnt_t'(MaxReads))
    else $error("threshold count beyond table size");

  a_full_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_is_load && !s1_q.start_table && (ref_cnt_q == cnt_t'(MaxReads)))
    |=> $stable(ref_cnt_q))
    else $error("load into full table changed count");

  a_block_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_is_load && s1_q.last_sample) |=> (err_cnt_q == '0))
    else $error("error count not cleared at block end");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_is_load && out_free) |=> !out_valid_q)
    else $error("load request produced a result");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds threshold loads and sample classify requests into the bin detector
// in random bursts while the result side stalls on its own pattern. Every
// result is checked field by field against a local model of the sorted
// threshold table, bin map and per-block error count.
// ----------------------------------------------------------------------------
module testbench;
  import mrtb_pkg::*;

  typedef struct packed {
    in_t  req;
    logic typed;
    out_t res;
  } step_t;

  localparam int NumDirected = 25;
  localparam int RandomItems = 1180;
  localparam int ErrRun      = 40;
  localparam int MaxReported = 50;

  logic clk_i;
  logic rst_ni;

  mrtb_in_if  req_if ();
  mrtb_out_if res_if ();

  multi_read_threshold_bin_detector_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // local copy of the threshold table
  sample_t sorted_thr  [MaxReads];
  sample_t arrival_thr [MaxReads];
  bin_t    region_bin  [MaxReads+1];
  int      table_size;
  errcnt_t block_err_count;

  out_t        pending_results [$];
  int          fail_count;
  int          items_done;
  int          burst_left;
  logic [31:0] ready_pattern;
  int          pattern_age;
  step_t       directed_steps [NumDirected];

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_thresholds();
    for (int j = 0; j < MaxReads; j++) begin
      sorted_thr[j]  = '0;
      arrival_thr[j] = '0;
    end
    for (int j = 0; j <= MaxReads; j++) region_bin[j] = '0;
    table_size = 0;
  endfunction

  // Updates the table or classifies; returns 1 when a result is due.
  function automatic logic classify_and_update(input in_t req, output out_t res);
    int                  pos;
    int                  region;
    logic                found;
    logic [MaxReads-1:0] code;
    logic                err;
    res = '0;
    if (req.func == FuncLoad) begin
      if (req.start_table) clear_thresholds();
      if (table_size < MaxReads) begin
        arrival_thr[table_size] = req.threshold;
        // equal values go after the stored one
        pos   = table_size;
        found = 1'b0;
        for (int j = 0; j < table_size; j++) begin
          if (!found && req.threshold < sorted_thr[j]) begin
            pos   = j;
            found = 1'b1;
          end
        end
        for (int j = table_size + 1; j > pos; j--) region_bin[j] = region_bin[j-1];
        region_bin[pos] = bin_t'(table_size + 1);
        for (int j = table_size; j > pos; j--) sorted_thr[j] = sorted_thr[j-1];
        sorted_thr[pos] = req.threshold;
        table_size++;
      end
      return 1'b0;
    end
    region = table_size;
    found  = 1'b0;
    for (int j = 0; j < table_size; j++) begin
      if (!found && req.sample < sorted_thr[j]) begin
        region = j;
        found  = 1'b1;
      end
    end
    // first read lands in the highest used bit
    code = '0;
    if (region < table_size) begin
      for (int j = 0; j < table_size; j++)
        code = {code[MaxReads-2:0], sorted_thr[region] <= arrival_thr[j]};
    end
    err = req.sample[SampleBits-1] ^ req.sent_bit;
    if (err && block_err_count != '1) block_err_count++;
    res.bin_id      = region_bin[region];
    res.soft_code   = code;
    res.hard_error  = err;
    res.error_count = block_err_count;
    res.block_end   = req.last_sample;
    if (req.last_sample) block_err_count = '0;
    return 1'b1;
  endfunction

  function automatic in_t load_req(int thr, logic start);
    in_t r;
    r.func        = FuncLoad;
    r.threshold   = sample_t'(thr);
    r.start_table = start;
    r.sample      = sample_t'($urandom);
    r.sent_bit    = 1'($urandom_range(0, 1));
    r.last_sample = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic in_t classify_req(int smp, logic sent, logic last);
    in_t r;
    r.func        = FuncClassify;
    r.threshold   = sample_t'($urandom);
    r.start_table = 1'($urandom_range(0, 1));
    r.sample      = sample_t'(smp);
    r.sent_bit    = sent;
    r.last_sample = last;
    return r;
  endfunction

  function automatic out_t result_of(int bin, int code, logic err, int cnt, logic blk_end);
    out_t r;
    r.bin_id      = bin_t'(bin);
    r.soft_code   = code[MaxReads-1:0];
    r.hard_error  = err;
    r.error_count = errcnt_t'(cnt);
    r.block_end   = blk_end;
    return r;
  endfunction

  function automatic int pick_sample();
    int offs;
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom_range(0, 1) ? 2047 : -2048;
      2, 3, 4, 5, 6: begin
        if (table_size > 0) begin
          offs = $urandom_range(0, 4);
          v    = int'(sorted_thr[$urandom_range(0, table_size - 1)]) + offs - 2;
        end else begin
          v = int'(sample_t'($urandom));
        end
      end
      default: v = int'(sample_t'($urandom));
    endcase
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v;
  endfunction

  function automatic int pick_threshold();
    int p;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 2047 : -2048;
      1, 2: begin
        // coarse grid so that equal thresholds turn up often
        p = $urandom_range(0, 4);
        return (p - 2) * 256;
      end
      default: return int'(sample_t'($urandom));
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MaxReported)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic send_request(input in_t req, input logic typed, input out_t typed_res);
    out_t res;
    logic has_res;
    logic ignored;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 16);
    end
    req_if.valid   = 1'b1;
    req_if.payload = req;
    do @(posedge clk_i); while (!req_if.ready);
    ignored = (req.func == FuncLoad) && !req.start_table && (table_size == MaxReads);
    has_res = classify_and_update(req, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
    if (!ignored) items_done++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    burst_left   = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // result side: rotating stall pattern; every fourth bit of a stall pattern is set
  always @(negedge clk_i) begin
    if (pattern_age == 0) begin
      pattern_age = $urandom_range(16, 96);
      case ($urandom_range(0, 2))
        0:       ready_pattern = '1;
        1:       ready_pattern = $urandom | 32'h8888_8888;
        default: ready_pattern = ($urandom & $urandom) | 32'h8888_8888;
      endcase
    end
    res_if.ready  = ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
    pattern_age--;
  end

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReported)
          $display("%0t: unexpected result, expected none, got %h", $time, res_if.payload);
      end else begin
        want = pending_results.pop_front();
        check_field("bin_id", 32'(want.bin_id), 32'(res_if.payload.bin_id));
        check_field("soft_code", 32'(want.soft_code), 32'(res_if.payload.soft_code));
        check_field("hard_error", 32'(want.hard_error), 32'(res_if.payload.hard_error));
        check_field("error_count", 32'(want.error_count),
                    32'(res_if.payload.error_count));
        check_field("block_end", 32'(want.block_end), 32'(res_if.payload.block_end));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("multi_read_threshold_bin_detector_core test failed");
    $finish;
  end

  initial begin
    in_t         req;
    int          n;
    int          len;
    int          smp;
    logic        open_block;
    logic        pressure_done;
    logic [63:0] raw;

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.payload  = '0;
    res_if.ready    = 1'b0;
    pattern_age     = 0;
    ready_pattern   = '1;
    burst_left      = 0;
    fail_count      = 0;
    items_done      = 0;
    block_err_count = '0;
    pressure_done   = 1'b0;
    clear_thresholds();

    // empty table, then build a full table, overflow it and restart
    directed_steps[0]  = '{classify_req(-2048, 1'b1, 1'b0), 1'b1,
                           result_of(0, 0, 1'b0, 0, 1'b0)};
    directed_steps[1]  = '{classify_req(2047, 1'b1, 1'b1), 1'b1,
                           result_of(0, 0, 1'b1, 1, 1'b1)};
    directed_steps[2]  = '{classify_req(0, 1'b0, 1'b0), 1'b1,
                           result_of(0, 0, 1'b0, 0, 1'b0)};
    directed_steps[3]  = '{classify_req(-1, 1'b0, 1'b0), 1'b1,
                           result_of(0, 0, 1'b1, 1, 1'b0)};
    directed_steps[4]  = '{load_req(0, 1'b1), 1'b0, '0};
    directed_steps[5]  = '{classify_req(-1, 1'b1, 1'b0), 1'b0, '0};
    directed_steps[6]  = '{classify_req(0, 1'b1, 1'b0), 1'b0, '0};
    directed_steps[7]  = '{load_req(2047, 1'b0), 1'b0, '0};
    directed_steps[8]  = '{load_req(-2048, 1'b0), 1'b0, '0};
    directed_steps[9]  = '{load_req(0, 1'b0), 1'b0, '0};
    directed_steps[10] = '{load_req(256, 1'b0), 1'b0, '0};
    directed_steps[11] = '{load_req(-256, 1'b0), 1'b0, '0};
    directed_steps[12] = '{load_req(1024, 1'b0), 1'b0, '0};
    directed_steps[13] = '{load_req(5, 1'b0), 1'b0, '0};
    directed_steps[14] = '{classify_req(-2048, 1'b1, 1'b0), 1'b0, '0};
    directed_steps[15] = '{classify_req(2047, 1'b0, 1'b0), 1'b0, '0};
    directed_steps[16] = '{classify_req(0, 1'b0, 1'b0), 1'b0, '0};
    directed_steps[17] = '{classify_req(255, 1'b0, 1'b0), 1'b0, '0};
    directed_steps[18] = '{classify_req(-257, 1'b1, 1'b0), 1'b0, '0};
    directed_steps[19] = '{classify_req(1024, 1'b0, 1'b1), 1'b0, '0};
    directed_steps[20] = '{load_req(2047, 1'b1), 1'b0, '0};
    directed_steps[21] = '{load_req(-2048, 1'b0), 1'b0, '0};
    directed_steps[22] = '{classify_req(-2048, 1'b1, 1'b0), 1'b0, '0};
    directed_steps[23] = '{load_req(-2048, 1'b0), 1'b0, '0};
    directed_steps[24] = '{classify_req(-2048, 1'b0, 1'b1), 1'b0, '0};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDirected; i++)
      send_request(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].res);

    // mostly table builds followed by sample blocks, some raw noise
    items_done = 0;
    while (items_done < RandomItems) begin
      if (!pressure_done && items_done >= RandomItems / 2) begin
        wait_drained();
        pressure_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: begin
          raw = {$urandom, $urandom};
          req = raw[$bits(in_t)-1:0];
          send_request(req, 1'b0, '0);
        end
        1, 2: begin
          n = $urandom_range(1, MaxReads + 1);
          for (int i = 0; i < n; i++)
            send_request(load_req(pick_threshold(),
                                  (i == 0) && ($urandom_range(0, 3) != 0)), 1'b0, '0);
        end
        default: begin
          len        = $urandom_range(1, 40);
          open_block = ($urandom_range(0, 7) == 0);
          for (int i = 0; i < len; i++)
            send_request(classify_req(pick_sample(), 1'($urandom_range(0, 1)),
                                      !open_block && (i == len - 1)), 1'b0, '0);
        end
      endcase
    end

    // one block of wrong decisions, closed by a sample with a random sent bit
    wait_drained();
    send_request(load_req(-300, 1'b1), 1'b0, '0);
    send_request(load_req(400, 1'b0), 1'b0, '0);
    send_request(load_req(-300, 1'b0), 1'b0, '0);
    for (int i = 0; i < ErrRun; i++) begin
      smp = pick_sample();
      send_request(classify_req(smp, smp >= 0, 1'b0), 1'b0, '0);
    end
    smp = pick_sample();
    send_request(classify_req(smp, 1'($urandom_range(0, 1)), 1'b1), 1'b0, '0);
    send_request(classify_req(pick_sample(), 1'($urandom_range(0, 1)), 1'b1), 1'b0, '0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("multi_read_threshold_bin_detector_core test passed");
    end else begin
      $display("multi_read_threshold_bin_detector_core test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/mrtb_pkg.sv
sv/mrtb_in_if.sv
sv/mrtb_out_if.sv
sv/multi_read_threshold_bin_detector_core.sv
test/testbench.sv
